@@ rtl/blta_pkg.sv @@
// ----------------------------------------------------------------------------
// blta_pkg
// Shared types, sizes, request codes and helper functions for the
// threshold ancestor unit (binary-lifting jump table over a rooted tree).
// ----------------------------------------------------------------------------
package blta_pkg;

  // Sizes
  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = 10;
  localparam int COUNT_W   = 11;
  localparam int COST_W    = 32;
  localparam int LEVELS    = 11;
  localparam int LVL_W     = 4;
  localparam int JT_ADDR_W = LVL_W + NODE_W;
  localparam int JT_DEPTH  = LEVELS * MAX_NODES;
  localparam int SPAN_W    = COUNT_W + 1;
  localparam int REQ_W     = 2;

  typedef logic [REQ_W-1:0]   req_t;
  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [COST_W-1:0]  cost_t;
  typedef logic [LVL_W-1:0]   level_t;

  // Request codes
  localparam req_t REQ_LOAD  = 2'd0;
  localparam req_t REQ_BUILD = 2'd1;
  localparam req_t REQ_QUERY = 2'd2;

  // One jump-table entry: ancestor and whether the chain reaches it
  typedef struct packed {
    logic  ok;
    node_t node;
  } jt_entry_t;

  // One node-store entry
  typedef struct packed {
    node_t parent;
    cost_t cost;
  } node_entry_t;

  // Write request into the node store
  typedef struct packed {
    logic        en;
    node_t       addr;
    node_entry_t data;
  } node_wr_t;

  // Clamp the node count to the store size
  function automatic count_t sat_count(count_t n);
    count_t res;
    res = (n > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : n;
    return res;
  endfunction

  // True when level lvl exists and 2^lvl is below n
  function automatic logic level_needed(level_t lvl, count_t n);
    logic [SPAN_W-1:0] span;
    span = SPAN_W'(1) << lvl;
    return (lvl < LVL_W'(LEVELS)) && (span < {1'b0, n});
  endfunction

  // floor(log2(n)) capped at the highest level
  function automatic level_t top_level(count_t n);
    level_t top;
    top = '0;
    for (int b = 0; b < COUNT_W; b++) begin
      if (n[b]) top = LVL_W'(b);
    end
    if (top > LVL_W'(LEVELS - 1)) top = LVL_W'(LEVELS - 1);
    return top;
  endfunction

endpackage

@@ rtl/binary_lifting_threshold_ancestor_unit.sv @@
// ----------------------------------------------------------------------------
// binary_lifting_threshold_ancestor_unit
// Threshold ancestor search over a rooted tree using a binary-lifting table.
// ----------------------------------------------------------------------------
// Notes for users: after reset the unit sweeps its node store and holds
// in_ready low meanwhile; cfg writes are taken at any time. A load is
// written straight into the node store. A build copies each parent into
// level 0 (node-store read, then jump-table write) and fills each further
// level row by row through the single jump-table read port (read the entry
// a level down, read its ancestor's entry, then write). A query visits each
// level from floor(log2(n)) down to 0, n = node count (jump-table read, then
// cost read, then compare); a start node at or above n skips the levels.
// The result sits in an output register, so the next transaction
// is accepted while it waits; a query stalls only if a second result is due
// before the first is taken. Node 0 is the root with parent 0 and cost 1;
// loads to it are dropped.
// ----------------------------------------------------------------------------
module binary_lifting_threshold_ancestor_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  blta_pkg::count_t      cfg_wr_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  blta_pkg::req_t        in_req_type,
  input  blta_pkg::node_t       in_node_index,
  input  blta_pkg::node_t       in_parent_index,
  input  blta_pkg::cost_t       in_node_cost,
  input  blta_pkg::cost_t       in_query_threshold,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output blta_pkg::node_t       out_ancestor_node
);
  import blta_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] S_B0_RD   = 4'd1;
  localparam logic [ST_W-1:0] S_B0_WR   = 4'd2;
  localparam logic [ST_W-1:0] S_BJ_RDA  = 4'd3;
  localparam logic [ST_W-1:0] S_BJ_RDB  = 4'd4;
  localparam logic [ST_W-1:0] S_BJ_WR   = 4'd5;
  localparam logic [ST_W-1:0] S_Q_LVL   = 4'd6;
  localparam logic [ST_W-1:0] S_Q_JD    = 4'd7;
  localparam logic [ST_W-1:0] S_Q_CD    = 4'd8;
  localparam logic [ST_W-1:0] S_Q_OUT   = 4'd9;

  // Control and working registers
  logic [ST_W-1:0] state_r, state_nxt;
  count_t          node_count_r, node_count_nxt;
  count_t          built_n_r, built_n_nxt;
  level_t          built_levels_r, built_levels_nxt;
  level_t          lvl_r, lvl_nxt;
  node_t           row_r, row_nxt;
  node_t           u_r, u_nxt;
  node_t           tgt_r, tgt_nxt;
  cost_t           thr_r, thr_nxt;
  logic            out_valid_r, out_valid_nxt;
  node_t           out_node_r, out_node_nxt;

  // Jump-table memory
  jt_entry_t              jt_mem [JT_DEPTH];
  jt_entry_t              jt_q_r;
  logic [JT_ADDR_W-1:0]   jt_rd_addr;
  logic                   jt_we;
  logic [JT_ADDR_W-1:0]   jt_wr_addr;
  jt_entry_t              jt_wr_data;

  // Node store
  node_wr_t    node_wr;
  node_t       node_rd_addr;
  node_entry_t node_rd;
  logic        clear_busy;

  // Helpers
  logic   in_acc;
  count_t n_now;
  logic   row_last;
  logic   more_levels;
  level_t lvl_inc;
  level_t lvl_dec;

  blta_node_store u_node_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_req     (node_wr),
    .rd_addr    (node_rd_addr),
    .rd_data    (node_rd),
    .clear_busy (clear_busy)
  );

  assign in_ready  = (state_r == S_IDLE) && !clear_busy;
  assign in_acc    = in_valid && in_ready;
  assign n_now     = sat_count(node_count_r);
  assign lvl_inc   = lvl_r + LVL_W'(1);
  assign lvl_dec   = lvl_r - LVL_W'(1);
  assign row_last  = (COUNT_W'({1'b0, row_r}) + COUNT_W'(1)) == built_n_r;
  assign more_levels = level_needed(lvl_inc, built_n_r);

  // Load transactions write the node store directly; root is fixed
  always_comb begin
    node_wr.en          = in_acc && (in_req_type == REQ_LOAD) && (in_node_index != '0);
    node_wr.addr        = in_node_index;
    node_wr.data.parent = in_parent_index;
    node_wr.data.cost   = in_node_cost;
  end

  // Main sequencer
  always_comb begin
    state_nxt        = state_r;
    node_count_nxt   = cfg_wr_en ? cfg_wr_data : node_count_r;
    built_n_nxt      = built_n_r;
    built_levels_nxt = built_levels_r;
    lvl_nxt          = lvl_r;
    row_nxt          = row_r;
    u_nxt            = u_r;
    tgt_nxt          = tgt_r;
    thr_nxt          = thr_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_node_nxt     = out_node_r;
    jt_rd_addr       = {lvl_r, u_r};
    jt_we            = 1'b0;
    jt_wr_addr       = {lvl_r, row_r};
    jt_wr_data       = '0;
    node_rd_addr     = row_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_req_type == REQ_BUILD) begin
            built_n_nxt      = n_now;
            built_levels_nxt = '0;
            lvl_nxt          = '0;
            row_nxt          = '0;
            if (n_now != '0) state_nxt = S_B0_RD;
          end else if (in_req_type == REQ_QUERY) begin
            u_nxt   = in_node_index;
            thr_nxt = in_query_threshold;
            lvl_nxt = top_level(n_now);
            if ({1'b0, in_node_index} >= n_now) state_nxt = S_Q_OUT;
            else state_nxt = S_Q_LVL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // Level 0: copy each parent
      S_B0_RD: begin
        node_rd_addr = row_r;
        state_nxt    = S_B0_WR;
      end

      S_B0_WR: begin
        jt_we           = 1'b1;
        jt_wr_data.ok   = 1'b1;
        jt_wr_data.node = node_rd.parent;
        if (row_last) begin
          built_levels_nxt = lvl_inc;
          if (more_levels) begin
            lvl_nxt   = lvl_inc;
            row_nxt   = '0;
            state_nxt = S_BJ_RDA;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          row_nxt   = row_r + NODE_W'(1);
          state_nxt = S_B0_RD;
        end
      end

      // Higher levels: ancestor of ancestor one level down
      S_BJ_RDA: begin
        jt_rd_addr = {lvl_dec, row_r};
        state_nxt  = S_BJ_RDB;
      end

      S_BJ_RDB: begin
        if (jt_q_r.ok && ({1'b0, jt_q_r.node} < built_n_r)) begin
          jt_rd_addr = {lvl_dec, jt_q_r.node};
          state_nxt  = S_BJ_WR;
        end else begin
          // Chain broken: mark the entry invalid and move on
          jt_we      = 1'b1;
          jt_wr_data = '0;
          if (row_last) begin
            built_levels_nxt = lvl_inc;
            if (more_levels) begin
              lvl_nxt   = lvl_inc;
              row_nxt   = '0;
              state_nxt = S_BJ_RDA;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            row_nxt   = row_r + NODE_W'(1);
            state_nxt = S_BJ_RDA;
          end
        end
      end

      S_BJ_WR: begin
        jt_we      = 1'b1;
        jt_wr_data = jt_q_r;
        if (row_last) begin
          built_levels_nxt = lvl_inc;
          if (more_levels) begin
            lvl_nxt   = lvl_inc;
            row_nxt   = '0;
            state_nxt = S_BJ_RDA;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          row_nxt   = row_r + NODE_W'(1);
          state_nxt = S_BJ_RDA;
        end
      end

      // Query: skip levels not built or rows outside the build
      S_Q_LVL: begin
        if ((lvl_r < built_levels_r) && ({1'b0, u_r} < built_n_r)) begin
          jt_rd_addr = {lvl_r, u_r};
          state_nxt  = S_Q_JD;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_OUT;
        end else begin
          lvl_nxt   = lvl_dec;
          state_nxt = S_Q_LVL;
        end
      end

      S_Q_JD: begin
        if (jt_q_r.ok) begin
          tgt_nxt      = jt_q_r.node;
          node_rd_addr = jt_q_r.node;
          state_nxt    = S_Q_CD;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_OUT;
        end else begin
          lvl_nxt   = lvl_dec;
          state_nxt = S_Q_LVL;
        end
      end

      // Jump when the ancestor's cost meets the threshold
      S_Q_CD: begin
        if (node_rd.cost >= thr_r) u_nxt = tgt_r;
        if (lvl_r == '0) begin
          state_nxt = S_Q_OUT;
        end else begin
          lvl_nxt   = lvl_dec;
          state_nxt = S_Q_LVL;
        end
      end

      // Hold the result until the output register is free
      S_Q_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = u_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      node_count_r   <= COUNT_W'(1);
      built_n_r      <= '0;
      built_levels_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      node_count_r   <= node_count_nxt;
      built_n_r      <= built_n_nxt;
      built_levels_r <= built_levels_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    row_r      <= row_nxt;
    u_r        <= u_nxt;
    tgt_r      <= tgt_nxt;
    thr_r      <= thr_nxt;
    out_node_r <= out_node_nxt;
  end

  // Jump-table memory: write and registered read
  always_ff @(posedge clk) begin
    if (jt_we) jt_mem[jt_wr_addr] <= jt_wr_data;
    jt_q_r <= jt_mem[jt_rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_ancestor_node = out_node_r;

endmodule

@@ rtl/blta_node_store.sv @@
// ----------------------------------------------------------------------------
// blta_node_store
// Parent and cost memory for every node, one write and one registered read
// port. After reset it sweeps the whole memory: parents to 0, costs to 0,
// and the root's cost to 1. It reports busy during that sweep.
// ----------------------------------------------------------------------------
module blta_node_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  blta_pkg::node_wr_t   wr_req,
  input  blta_pkg::node_t      rd_addr,
  output blta_pkg::node_entry_t rd_data,
  output logic                 clear_busy
);
  import blta_pkg::*;

  node_entry_t mem [MAX_NODES];
  node_entry_t rd_q_r;
  logic        clr_active_r;
  logic        clr_active_nxt;
  node_t       clr_idx_r;
  node_t       clr_idx_nxt;

  logic        we;
  node_t       wa;
  node_entry_t wd;

  // Select the clearing sweep over regular writes
  always_comb begin
    if (clr_active_r) begin
      we         = 1'b1;
      wa         = clr_idx_r;
      wd.parent  = '0;
      wd.cost    = (clr_idx_r == '0) ? COST_W'(1) : '0;
    end else begin
      we = wr_req.en;
      wa = wr_req.addr;
      wd = wr_req.data;
    end
  end

  // Advance the sweep until the last entry
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    if (clr_active_r) begin
      clr_idx_nxt = clr_idx_r + NODE_W'(1);
      if (clr_idx_r == NODE_W'(MAX_NODES - 1)) clr_active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
    end
  end

  // Memory: write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q_r <= mem[rd_addr];
  end

  assign rd_data    = rd_q_r;
  assign clear_busy = clr_active_r;

endmodule

@@ tb/ancestor_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ancestor_checker
// Passive checker for the threshold ancestor unit. It mirrors the node store,
// the jump table and the node count, works out the ancestor each accepted
// query must return, and compares every result transaction against the
// oldest outstanding answer.
// ----------------------------------------------------------------------------
module ancestor_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  blta_pkg::count_t      cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  blta_pkg::req_t        in_req_type,
  input  blta_pkg::node_t       in_node_index,
  input  blta_pkg::node_t       in_parent_index,
  input  blta_pkg::cost_t       in_node_cost,
  input  blta_pkg::cost_t       in_query_threshold,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  blta_pkg::node_t       out_ancestor_node,
  output int                    mismatch_count,
  output int                    results_owed
);
  import blta_pkg::*;

  // Mirror of the unit's storage
  cost_t  cost_mem    [MAX_NODES];
  node_t  parent_mem  [MAX_NODES];
  node_t  jump_mem    [LEVELS][MAX_NODES];
  bit     jump_ok     [LEVELS][MAX_NODES];
  bit     level_built [LEVELS];
  count_t node_count_q;

  // Answers owed to queries already accepted, oldest first
  node_t  expected_ancestors[$];

  function automatic int nodes_in_use();
    return (node_count_q > COUNT_W'(MAX_NODES)) ? MAX_NODES : int'(node_count_q);
  endfunction

  function automatic void clear_mirror();
    for (int i = 0; i < MAX_NODES; i++) begin
      cost_mem[i]   = '0;
      parent_mem[i] = '0;
      for (int j = 0; j < LEVELS; j++) begin
        jump_mem[j][i] = '0;
        jump_ok[j][i]  = 1'b0;
      end
    end
    for (int j = 0; j < LEVELS; j++) level_built[j] = 1'b0;
    cost_mem[0]  = cost_t'(1);
    node_count_q = count_t'(1);
  endfunction

  // Fill level 0 with parents, then each level by doubling the one below
  function automatic void rebuild_jump_table();
    int n;
    int mid;
    n = nodes_in_use();
    for (int j = 0; j < LEVELS; j++) begin
      level_built[j] = 1'b0;
      for (int i = 0; i < MAX_NODES; i++) jump_ok[j][i] = 1'b0;
    end
    if (n == 0) return;
    for (int i = 0; i < n; i++) begin
      jump_mem[0][i] = parent_mem[i];
      jump_ok[0][i]  = 1'b1;
    end
    level_built[0] = 1'b1;
    for (int j = 1; j < LEVELS && (1 << j) < n; j++) begin
      for (int i = 0; i < n; i++) begin
        if (jump_ok[j-1][i]) begin
          mid = jump_mem[j-1][i];
          if (jump_ok[j-1][mid]) begin
            jump_mem[j][i] = jump_mem[j-1][mid];
            jump_ok[j][i]  = 1'b1;
          end
        end
      end
      level_built[j] = 1'b1;
    end
  endfunction

  // Climb from the top level down, jumping while the ancestor's cost holds
  function automatic node_t climb_to_threshold(node_t start, cost_t threshold);
    int n;
    int top_lv;
    int u;
    int dest;
    n = nodes_in_use();
    u = start;
    if (u >= n) return start;
    top_lv = 0;
    while (top_lv + 1 < LEVELS && (2 << top_lv) <= n) top_lv++;
    for (int lv = top_lv; lv >= 0; lv--) begin
      if (level_built[lv] && jump_ok[lv][u]) begin
        dest = jump_mem[lv][u];
        if (cost_mem[dest] >= threshold) u = dest;
      end
    end
    return node_t'(u);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_mirror();
      expected_ancestors.delete();
      mismatch_count = 0;
    end else begin
      // Check the result transaction against the oldest answer
      if (out_valid && out_ready) begin
        if (expected_ancestors.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result: ancestor %0d with no query pending",
                     $time, out_ancestor_node);
        end else begin
          node_t want;
          want = expected_ancestors.pop_front();
          if (out_ancestor_node !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("[%0t] ancestor mismatch: expected %0d, got %0d",
                       $time, want, out_ancestor_node);
          end
        end
      end

      // Apply the accepted request transaction
      if (in_valid && in_ready) begin
        case (in_req_type)
          REQ_LOAD: begin
            if (in_node_index != '0) begin
              parent_mem[in_node_index] = in_parent_index;
              cost_mem[in_node_index]   = in_node_cost;
            end
          end
          REQ_BUILD: rebuild_jump_table();
          REQ_QUERY: expected_ancestors.push_back(
                       climb_to_threshold(in_node_index, in_query_threshold));
          default: ;
        endcase
      end

      // New node count takes effect from the next transaction on
      if (cfg_wr_en) node_count_q = cfg_wr_data;
    end
    results_owed = expected_ancestors.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the threshold ancestor unit with loads, builds, queries and junk
// requests across several node counts, with random gaps on both channels.
// The checker beside the unit predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
  import blta_pkg::*;

  localparam int   MAX_GAP       = 13;
  localparam int   RANDOM_ITEMS  = 700;
  localparam int   SETTLE_CYCLES = 40;          // longest query plus margin
  localparam int   RUN_LIMIT_NS  = 20_000_000;
  localparam req_t REQ_UNKNOWN   = 2'd3;

  logic   clk;
  logic   rst_n;
  logic   cfg_wr_en;
  count_t cfg_wr_data;
  logic   in_valid;
  logic   in_ready;
  req_t   in_req_type;
  node_t  in_node_index;
  node_t  in_parent_index;
  cost_t  in_node_cost;
  cost_t  in_query_threshold;
  logic   out_valid;
  logic   out_ready;
  node_t  out_ancestor_node;
  int     mismatches;
  int     results_owed;

  // Stimulus bookkeeping: which nodes carry a written cost
  bit     node_loaded [MAX_NODES];
  cost_t  cost_shadow [MAX_NODES];
  int     loaded_list[$];
  int     last_loaded;
  int     cur_count;
  int     work_items;
  bit     in_idle_on;
  bit     out_idle_on;

  binary_lifting_threshold_ancestor_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_node_index      (in_node_index),
    .in_parent_index    (in_parent_index),
    .in_node_cost       (in_node_cost),
    .in_query_threshold (in_query_threshold),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ancestor_node  (out_ancestor_node)
  );

  ancestor_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_node_index      (in_node_index),
    .in_parent_index    (in_parent_index),
    .in_node_cost       (in_node_cost),
    .in_query_threshold (in_query_threshold),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ancestor_node  (out_ancestor_node),
    .mismatch_count     (mismatches),
    .results_owed       (results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hold the request after an idle gap until the unit takes the transaction
  task automatic send_item(req_t req, int idx, int par, cost_t cost, cost_t thr);
    int gap;
    if ($urandom_range(0, 29) == 0) in_idle_on = !in_idle_on;
    gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type        = req;
    in_node_index      = node_t'(idx);
    in_parent_index    = node_t'(par);
    in_node_cost       = cost;
    in_query_threshold = thr;
    in_valid           = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (req == REQ_LOAD && idx != 0) begin
      cost_shadow[idx] = cost;
      if (!node_loaded[idx]) loaded_list.push_back(idx);
      node_loaded[idx] = 1'b1;
      last_loaded      = idx;
    end
    work_items++;
  endtask

  task automatic load_node(int idx, int par, cost_t cost);
    send_item(REQ_LOAD, idx, par, cost, $urandom);
  endtask

  task automatic query_node(int idx, cost_t thr);
    send_item(REQ_QUERY, idx, $urandom_range(0, MAX_NODES - 1), $urandom, thr);
  endtask

  task automatic start_build();
    send_item(REQ_BUILD, $urandom_range(0, MAX_NODES - 1),
              $urandom_range(0, MAX_NODES - 1), $urandom, $urandom);
  endtask

  // Change the node count only once the unit has drained
  task automatic write_node_count(int value);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = count_t'(value);
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cur_count   = value;
  endtask

  function automatic int nodes_live();
    return (cur_count > MAX_NODES) ? MAX_NODES : cur_count;
  endfunction

  function automatic int pick_load_index();
    int span;
    span = (nodes_live() >= 2) ? nodes_live() : MAX_NODES;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, span - 1);
    return $urandom_range(1, MAX_NODES - 1);
  endfunction

  // Parents only point at nodes whose cost is already written
  function automatic int pick_parent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return last_loaded;
    if (r < 80) return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    return 0;
  endfunction

  // Mostly costs that grow away from the root, some noise
  function automatic cost_t pick_cost(int par);
    int r;
    longint unsigned sum;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      sum = longint'(cost_shadow[par]) + $urandom_range(0, 1 << $urandom_range(0, 24));
      return (sum > 64'hFFFF_FFFF) ? '1 : cost_t'(sum);
    end
    if (r < 80) return $urandom;
    if (r < 90) return '0;
    return '1;
  endfunction

  function automatic cost_t pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return cost_shadow[loaded_list[$urandom_range(0, loaded_list.size() - 1)]]
             + $urandom_range(0, 2) - 1;
    if (r < 65) return '0;
    if (r < 75) return '1;
    return $urandom;
  endfunction

  function automatic int pick_query_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return last_loaded;
    if (r < 60) return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    if (r < 85 && nodes_live() > 0) return $urandom_range(0, nodes_live() - 1);
    return $urandom_range(0, MAX_NODES - 1);
  endfunction

  // One node count: grow the tree, build, then mostly queries
  task automatic random_phase();
    int r;
    int par;
    r = $urandom_range(0, 99);
    if (r < 12)      write_node_count(MAX_NODES);
    else if (r < 17) write_node_count($urandom_range(MAX_NODES + 1, 2047));
    else if (r < 22) write_node_count($urandom_range(0, 1));
    else if (r < 40) write_node_count(1 << $urandom_range(1, 9));
    else             write_node_count($urandom_range(2, 96));

    repeat ($urandom_range(4, 24)) begin
      par = pick_parent();
      load_node(pick_load_index(), par, pick_cost(par));
    end
    start_build();

    repeat ($urandom_range(30, 80)) begin
      if (work_items >= RANDOM_ITEMS) break;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        query_node(pick_query_index(), pick_threshold());
      end else if (r < 82) begin
        par = pick_parent();
        load_node(pick_load_index(), par, pick_cost(par));
      end else if (r < 86 && nodes_live() <= 256) begin
        start_build();
      end else if (r < 92) begin
        load_node(0, $urandom_range(0, MAX_NODES - 1), $urandom);
      end else begin
        send_item(REQ_UNKNOWN, $urandom_range(0, MAX_NODES - 1),
                  $urandom_range(0, MAX_NODES - 1), $urandom, $urandom);
      end
    end
    // Close with a query so its answer marks the unit idle
    query_node(pick_query_index(), pick_threshold());
  endtask

  // Result side: stall a random number of cycles before each transaction
  initial begin : result_sink
    int stall;
    out_ready   = 1'b0;
    out_idle_on = 1'b1;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
      stall = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_valid           = 1'b0;
    in_req_type        = REQ_LOAD;
    in_node_index      = '0;
    in_parent_index    = '0;
    in_node_cost       = '0;
    in_query_threshold = '0;
    in_idle_on         = 1'b1;
    work_items         = 0;
    cur_count          = 1;
    for (int i = 0; i < MAX_NODES; i++) begin
      node_loaded[i] = 1'b0;
      cost_shadow[i] = '0;
    end
    node_loaded[0] = 1'b1;
    cost_shadow[0] = cost_t'(1);
    loaded_list.push_back(0);
    last_loaded = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, root load, junk request, stale table
    write_node_count(MAX_NODES);
    load_node(1, 0, 32'hFFFF_FFFF);
    load_node(1023, 1, 32'h0000_0000);
    load_node(2, 1023, 32'hA5A5_A5A5);
    load_node(512, 2, 32'h5A5A_5A5A);
    load_node(3, 512, 32'd100);
    load_node(0, 7, 32'h0000_1234);
    send_item(REQ_UNKNOWN, 1023, 1023, '1, '1);
    start_build();
    query_node(3, '0);
    query_node(3, '1);
    query_node(1023, cost_t'(1));
    query_node(512, 32'h5A5A_5A5A);
    query_node(1000, '0);
    load_node(2, 1, cost_t'(1));
    query_node(3, cost_t'(2));

    // Empty tree, then a count past the store, then a single node
    write_node_count(0);
    query_node(0, '0);
    start_build();
    query_node(5, '0);
    write_node_count(2047);
    query_node(1023, '0);
    start_build();
    query_node(3, '0);
    write_node_count(1);
    query_node(0, '1);
    query_node(1, '0);

    // Parent beyond the node count is still a level-0 target
    write_node_count(4);
    start_build();
    query_node(3, '0);

    work_items = 0;
    while (work_items < RANDOM_ITEMS) random_phase();

    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
